/* design/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define ASSERT_STD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

/* design/tqt_pkg.sv */
// Types, constants and helper function of the traffic quota table.
`default_nettype none
package tqt_pkg;

  typedef enum logic [2:0] {
    KIND_CHECK   = 3'd0,
    KIND_ACCOUNT = 3'd1,
    KIND_PERIOD  = 3'd2,
    KIND_WRITE   = 3'd3,
    KIND_REMOVE  = 3'd4,
    KIND_READ    = 3'd5
  } kind_e;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [63:0] LIMIT_UNLIMITED = {64{1'b1}};

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        user_id;
    logic [31:0]        group_id;
    logic [31:0]        amount;
    logic               skip_sum;
    logic [5:0]         slot;
    logic [7:0]         period_type;
    logic signed [63:0] limit_value;
    logic [62:0]        initial_traffic;
    logic               blocked;
    logic               keep_counters;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic        hit;
    logic [62:0] traffic_out;
    logic [62:0] delta_out;
    logic        active;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] user;
    logic [31:0] group;
    logic [7:0]  period;
    logic [63:0] limit;
    logic [62:0] traffic;
    logic [62:0] delta;
    logic        blocked;
  } entry_t;

  // Entry is neither blocked nor at its limit; any negative limit but -1 counts as reached.
  function automatic logic is_active(entry_t e);
    logic res;
    if (e.blocked) begin
      res = 1'b0;
    end else if (e.limit == LIMIT_UNLIMITED) begin
      res = 1'b1;
    end else if (e.limit[63]) begin
      res = 1'b0;
    end else begin
      res = (e.traffic < e.limit[62:0]);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/tqt_chan_if.sv */
// Valid/ready channel interfaces for request and result items.
`default_nettype none
interface tqt_req_if import tqt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tqt_res_if import tqt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/tqt_mem.sv */
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module tqt_mem import tqt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/tqt_satadd.sv */
// Shared saturating adder for the 63-bit traffic and delta counters.
`default_nettype none
module tqt_satadd import tqt_pkg::*; (
  input  wire logic [62:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [62:0] sum_o
);

  logic [63:0] wide;

  assign wide  = {1'b0, a_i} + {32'd0, b_i};
  assign sum_o = wide[63] ? MAX63 : wide[62:0];

endmodule
`default_nettype wire

/* design/traffic_quota_table_top.sv */
// Top level of the traffic quota table: sequencer, result register, memory and adder.
//
//   channel | dir | role
//   --------+-----+-----------------------------------------------------------
//   req_i   | in  | command item: check, account, period reset, write, remove, read
//   res_o   | out | one result item per command
//
// Check, account and period reset scan the table one slot per memory read; a lookup
// stops at its first hit, and an account that does not skip the sum then adds to
// traffic (ACC_T) and to delta (ACC_D). Write, remove and read step through read slot,
// write slot, result and idle.
// After reset a clearing pass over every slot wipes the valid flags;
// req_i.ready stays low meanwhile and while a command is in work.
// A stalled res_o holds one finished result; a new item is taken meanwhile.
`default_nettype none
`include "assert_macros.svh"
module traffic_quota_table_top import tqt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tqt_req_if.sink    req_i,
  tqt_res_if.source  res_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CLEAR   = 9'b000000010,
    ST_SCAN    = 9'b000000100,
    ST_ACC_T   = 9'b000001000,
    ST_ACC_D   = 9'b000010000,
    ST_SLOT_RD = 9'b000100000,
    ST_SLOT_OP = 9'b001000000,
    ST_DONE    = 9'b010000000,
    ST_SPARE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Scan control: cnt_q is the next slot to read, pend_q marks rdata as a live slot.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;

  // Payload registers.
  req_t        req_q;
  res_t        work_q, work_d;
  logic [62:0] tsum_q, tsum_d;
  res_t        out_q;
  logic        out_valid_q;
  logic        out_load;

  // Memory port.
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, rdata;

  // Shared adder.
  logic [62:0] add_a, add_sum;

  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             key_match, per_match, is_lookup, scan_end;

  tqt_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Traffic add first (ACC_T), delta add next (ACC_D).
  assign add_a = (state_q == ST_ACC_T) ? rdata.traffic : rdata.delta;

  tqt_satadd u_add (
    .a_i   (add_a),
    .b_i   (req_q.amount),
    .sum_o (add_sum)
  );

  assign slot_ok   = (32'(req_q.slot) < ENTRIES);
  assign slot_idx  = IDX_W'(req_q.slot);
  assign key_match = pend_q && rdata.valid && (rdata.user == req_q.user_id)
                     && (rdata.group == req_q.group_id);
  assign per_match = pend_q && rdata.valid && (rdata.period == req_q.period_type);
  assign is_lookup = (req_q.kind == KIND_CHECK) || (req_q.kind == KIND_ACCOUNT);
  assign scan_end  = (cnt_q == CNT_W'(ENTRIES));

  assign req_i.ready = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    work_d    = work_q;
    tsum_d    = tsum_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pidx_q;
    mem_raddr = cnt_q[IDX_W-1:0];
    mem_wdata = rdata;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          work_d = '0;
          cnt_d  = '0;
          pend_d = 1'b0;
          case (req_i.data.kind)
            KIND_CHECK, KIND_ACCOUNT, KIND_PERIOD: state_d = ST_SCAN;
            KIND_WRITE, KIND_REMOVE, KIND_READ:    state_d = ST_SLOT_RD;
            default:                               state_d = ST_DONE;
          endcase
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IDX_W-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (is_lookup && key_match) begin
          // First match wins; rdata holds the entry since no read is issued.
          work_d.hit     = 1'b1;
          work_d.allowed = (req_q.kind == KIND_CHECK) && is_active(rdata);
          if ((req_q.kind == KIND_ACCOUNT) && !req_q.skip_sum) begin
            state_d = ST_ACC_T;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          if ((req_q.kind == KIND_PERIOD) && per_match) begin
            mem_we            = 1'b1;
            mem_wdata.traffic = '0;
          end
          if (scan_end) begin
            pend_d = 1'b0;
            // A missed check allows; other kinds report not allowed.
            work_d.allowed = (req_q.kind == KIND_CHECK);
            state_d        = ST_DONE;
          end else begin
            mem_re = 1'b1;
            pidx_d = cnt_q[IDX_W-1:0];
            cnt_d  = cnt_q + 1'b1;
            pend_d = 1'b1;
          end
        end
      end

      ST_ACC_T: begin
        tsum_d  = add_sum;
        state_d = ST_ACC_D;
      end

      ST_ACC_D: begin
        mem_we            = 1'b1;
        mem_wdata.traffic = tsum_q;
        mem_wdata.delta   = add_sum;
        state_d           = ST_DONE;
      end

      ST_SLOT_RD: begin
        if (slot_ok) begin
          mem_re    = 1'b1;
          mem_raddr = slot_idx;
          state_d   = ST_SLOT_OP;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_SLOT_OP: begin
        mem_waddr = slot_idx;
        case (req_q.kind)
          KIND_WRITE: begin
            mem_we            = 1'b1;
            mem_wdata.valid   = 1'b1;
            mem_wdata.user    = req_q.user_id;
            mem_wdata.group   = req_q.group_id;
            mem_wdata.period  = req_q.period_type;
            mem_wdata.limit   = req_q.limit_value;
            mem_wdata.blocked = req_q.blocked;
            // Nothing to keep on an empty slot: load as an insert.
            if (!req_q.keep_counters || !rdata.valid) begin
              mem_wdata.traffic = req_q.initial_traffic;
              mem_wdata.delta   = '0;
            end
          end
          KIND_REMOVE: begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
          end
          KIND_READ: begin
            if (rdata.valid) begin
              work_d.hit         = 1'b1;
              work_d.traffic_out = rdata.traffic;
              work_d.delta_out   = rdata.delta;
              work_d.active      = is_active(rdata);
              mem_we             = 1'b1;
              mem_wdata.delta    = '0;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_load || (out_valid_q && !res_o.ready);
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    work_q <= work_d;
    pidx_q <= pidx_d;
    tsum_q <= tsum_d;
    if (out_load) begin
      out_q <= work_q;
    end
  end

  // Assertions.
  `ASSERT_STD(a_busy_after_accept, (req_i.valid && req_i.ready) |=> !req_i.ready,
              "block ready right after taking an item")
  `ASSERT_STD(a_scan_bound, (state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(ENTRIES)),
              "scan counter past the table end")
  `ASSERT_STD(a_scan_write_period,
              (mem_we && (state_q == ST_SCAN)) |-> (req_q.kind == KIND_PERIOD),
              "table written during a lookup scan")
  `ASSERT_STD(a_done_needs_room,
              (out_valid_q && !res_o.ready && (state_q == ST_DONE)) |=> (state_q == ST_DONE),
              "result left DONE while the output register was full")

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the traffic quota table: directed table, then random commands.
module tb;
  import tqt_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int NUM_RANDOM   = 750;
  localparam int KEYS         = 8;
  localparam int STALL_LIMIT  = 5000;  // far above a full scan plus the worst result stalls
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    req_t cmd;
    bit   fixed;  // want holds a hand-typed result
    res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  tqt_req_if req_if ();
  tqt_res_if res_if ();

  traffic_quota_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Shadow copy of the quota table and the results still to come.
  entry_t   quota_tab [ENTRIES];
  res_t     outcome_q [$];
  dir_row_t rows      [$];

  logic [31:0] pool_user  [KEYS];
  logic [31:0] pool_group [KEYS];

  int errors       = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Open unless blocked or traffic has reached the limit; -1 never runs out, and a
  // non-negative count is never below any other negative limit.
  function automatic bit within_quota(entry_t e);
    if (e.blocked) return 1'b0;
    if (e.limit == LIMIT_UNLIMITED) return 1'b1;
    return $signed({1'b0, e.traffic}) < $signed(e.limit);
  endfunction

  function automatic int find_key(logic [31:0] u, logic [31:0] g);
    for (int i = 0; i < ENTRIES; i++) begin
      if (quota_tab[i].valid && quota_tab[i].user == u && quota_tab[i].group == g) return i;
    end
    return -1;
  endfunction

  function automatic logic [62:0] add_sat(logic [62:0] a, logic [31:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {32'd0, b};
    return s[63] ? MAX63 : s[62:0];
  endfunction

  // Applies one command to the shadow table and returns the result it must produce.
  // The slot field is 6 bits wide and the table 64 deep, so every slot is in range.
  function automatic res_t quota_step(req_t c);
    res_t r;
    int   i;
    r = '0;
    case (c.kind)
      KIND_CHECK: begin
        i = find_key(c.user_id, c.group_id);
        r.hit = (i >= 0);
        if (i < 0) r.allowed = 1'b1;
        else r.allowed = within_quota(quota_tab[i]);
      end
      KIND_ACCOUNT: begin
        i = find_key(c.user_id, c.group_id);
        r.hit = (i >= 0);
        if (i >= 0 && !c.skip_sum) begin
          quota_tab[i].traffic = add_sat(quota_tab[i].traffic, c.amount);
          quota_tab[i].delta   = add_sat(quota_tab[i].delta, c.amount);
        end
      end
      KIND_PERIOD: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (quota_tab[k].valid && quota_tab[k].period == c.period_type)
            quota_tab[k].traffic = '0;
        end
      end
      KIND_WRITE: begin
        // keep on an empty slot has nothing to keep and loads like an insert
        if (!c.keep_counters || !quota_tab[c.slot].valid) begin
          quota_tab[c.slot].traffic = c.initial_traffic;
          quota_tab[c.slot].delta   = '0;
        end
        quota_tab[c.slot].user    = c.user_id;
        quota_tab[c.slot].group   = c.group_id;
        quota_tab[c.slot].period  = c.period_type;
        quota_tab[c.slot].limit   = c.limit_value;
        quota_tab[c.slot].blocked = c.blocked;
        quota_tab[c.slot].valid   = 1'b1;
      end
      KIND_REMOVE: quota_tab[c.slot].valid = 1'b0;
      KIND_READ: begin
        if (quota_tab[c.slot].valid) begin
          r.hit         = 1'b1;
          r.traffic_out = quota_tab[c.slot].traffic;
          r.delta_out   = quota_tab[c.slot].delta;
          r.active      = within_quota(quota_tab[c.slot]);
          quota_tab[c.slot].delta = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t mk_cmd(kind_e k, logic [31:0] u, logic [31:0] g, logic [31:0] amt,
                                  logic skip, logic [5:0] sl, logic [7:0] per,
                                  logic [63:0] lim, logic [62:0] init, logic blk, logic keep);
    req_t c;
    c.kind            = k;
    c.user_id         = u;
    c.group_id        = g;
    c.amount          = amt;
    c.skip_sum        = skip;
    c.slot            = sl;
    c.period_type     = per;
    c.limit_value     = lim;
    c.initial_traffic = init;
    c.blocked         = blk;
    c.keep_counters   = keep;
    return c;
  endfunction

  function automatic res_t mk_res(logic alw, logic h, logic [62:0] tr, logic [62:0] dl,
                                  logic act);
    res_t r;
    r.allowed     = alw;
    r.hit         = h;
    r.traffic_out = tr;
    r.delta_out   = dl;
    r.active      = act;
    return r;
  endfunction

  function automatic void add_row(req_t c, bit fixed, res_t want);
    dir_row_t row;
    row.cmd   = c;
    row.fixed = fixed;
    row.want  = want;
    rows.push_back(row);
  endfunction

  // Mostly well-formed traffic on a small key pool and low slots, so lookups hit
  // and shadow each other; the rest is random keys and random field values.
  function automatic req_t random_cmd();
    req_t        c;
    logic [63:0] w;
    int          k;
    int          pick;
    w = {$urandom(), $urandom()};
    c.user_id         = $urandom();
    c.group_id        = $urandom();
    c.amount          = $urandom();
    c.skip_sum        = 1'($urandom_range(1));
    c.slot            = 6'($urandom_range(63));
    c.period_type     = 8'($urandom_range(255));
    c.limit_value     = {$urandom(), $urandom()};
    c.initial_traffic = w[62:0];
    c.blocked         = 1'($urandom_range(1));
    c.keep_counters   = 1'($urandom_range(1));
    k = $urandom_range(KEYS - 1);
    if ($urandom_range(99) < 85) begin
      c.user_id  = pool_user[k];
      c.group_id = pool_group[k];
    end
    if ($urandom_range(99) < 70) c.slot = 6'($urandom_range(15));
    if ($urandom_range(99) < 85) c.period_type = 8'($urandom_range(3, 1));
    if ($urandom_range(99) < 80) c.amount = $urandom_range(2000);
    if ($urandom_range(99) < 80) c.skip_sum = ($urandom_range(9) == 0);
    if ($urandom_range(99) < 70) c.blocked = 1'b0;
    case ($urandom_range(5))
      0:       c.limit_value = LIMIT_UNLIMITED;
      1:       ;  // any 64-bit pattern, sign bit included
      2:       c.limit_value = 64'($urandom_range(5000));
      3:       c.limit_value = {1'b1, 31'd0, 32'($urandom())};
      default: c.limit_value = 64'($urandom_range(1 << 20));
    endcase
    case ($urandom_range(3))
      0, 1: c.initial_traffic = 63'($urandom_range(5000));
      2:    c.initial_traffic = MAX63 - 63'($urandom_range(3000));
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < 30)      c.kind = KIND_CHECK;
    else if (pick < 58) c.kind = KIND_ACCOUNT;
    else if (pick < 65) c.kind = KIND_PERIOD;
    else if (pick < 82) c.kind = KIND_WRITE;
    else if (pick < 88) c.kind = KIND_REMOVE;
    else                c.kind = KIND_READ;
    return c;
  endfunction

  // Thirds of the run: sender seldom idle / receiver mostly stalled, then swapped,
  // then both flat out.
  function automatic void set_pacing(int idx, int total);
    case ((idx * 3) / total)
      0:       begin src_idle_pct = 6;  snk_idle_pct = 86; end
      1:       begin src_idle_pct = 86; snk_idle_pct = 6;  end
      default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
    endcase
  endfunction

  // Offers one item, waits for the handshake, then records what must come back.
  task automatic send_cmd(input req_t c, input bit fixed, input res_t want);
    res_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= c;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = quota_step(c);
    outcome_q.push_back(fixed ? want : pred);
  endtask

  function automatic void note_mismatch(string what, logic [62:0] want, logic [62:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stalls, checking, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = res_if.data;
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("result item with no command outstanding: %p", got);
      end else begin
        want = outcome_q.pop_front();
        if (got.allowed !== want.allowed) note_mismatch("allowed", want.allowed, got.allowed);
        if (got.hit !== want.hit) note_mismatch("hit", want.hit, got.hit);
        if (got.traffic_out !== want.traffic_out)
          note_mismatch("traffic_out", want.traffic_out, got.traffic_out);
        if (got.delta_out !== want.delta_out)
          note_mismatch("delta_out", want.delta_out, got.delta_out);
        if (got.active !== want.active) note_mismatch("active", want.active, got.active);
      end
    end
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("traffic_quota_table_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    req_t        c;
    logic [31:0] u_lo;
    logic [31:0] u_hi;
    logic [31:0] u_mix;
    logic [31:0] g_mix;
    logic [63:0] lim_min;
    logic [63:0] lim_max;
    res_t        none;
    int          total;
    int          idx;

    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    for (int i = 0; i < ENTRIES; i++) quota_tab[i] = '0;

    // some pool keys share a user and differ only in group
    for (int k = 0; k < KEYS; k++) begin
      pool_user[k]  = (k % 2 == 1) ? pool_user[k-1] : $urandom();
      pool_group[k] = $urandom();
    end

    u_lo    = 32'h0000_0000;
    u_hi    = 32'hFFFF_FFFF;
    u_mix   = 32'hA5A5_A5A5;
    g_mix   = 32'h5A5A_5A5A;
    lim_min = 64'h8000_0000_0000_0000;
    lim_max = 64'h7FFF_FFFF_FFFF_FFFF;
    none    = '0;

    // empty table: check misses and allows, read and account report nothing
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(1, 0, 0, 0, 0));
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0), 1, none);
    add_row(mk_cmd(KIND_ACCOUNT, u_hi, u_hi, u_hi, 0, 0, 0, 0, 0, 0, 0), 1, none);
    // unlimited entry loaded at the saturation point, then a full-width account
    add_row(mk_cmd(KIND_WRITE, u_hi, u_hi, 0, 0, 0, 1, LIMIT_UNLIMITED, MAX63, 0, 0), 1, none);
    add_row(mk_cmd(KIND_CHECK, u_hi, u_hi, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(1, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_ACCOUNT, u_hi, u_hi, u_hi, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, MAX63, 63'h0FFFF_FFFF, 1));
    // limit 100, one byte short; skipped account leaves it there
    add_row(mk_cmd(KIND_WRITE, u_lo, u_lo, 0, 0, 5, 2, 100, 99, 0, 0), 1, none);
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(1, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_ACCOUNT, u_lo, u_lo, 1, 1, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_cmd(KIND_ACCOUNT, u_lo, u_lo, 1, 0, 0, 0, 0, 0, 0, 0), 0, none);
    // traffic equal to the limit denies
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_PERIOD, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0), 1, none);
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    // same key in a lower slot, most negative limit, keep on an empty slot
    add_row(mk_cmd(KIND_WRITE, u_lo, u_lo, 0, 0, 3, 3, lim_min, 7, 0, 1), 1, none);
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, 0, 0, 0));
    // update keeping counters, blocked, largest limit
    add_row(mk_cmd(KIND_WRITE, u_lo, u_lo, 0, 0, 3, 3, lim_max, 12345, 1, 1), 0, none);
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_cmd(KIND_REMOVE, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0), 1, none);
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0), 1, none);
    // removal uncovers the entry in slot 5 again
    add_row(mk_cmd(KIND_CHECK, u_lo, u_lo, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 5, 0, 0, 0, 0, 0), 0, none);
    // last slot, period 255, zero limit, blocked
    add_row(mk_cmd(KIND_WRITE, u_mix, g_mix, 0, 0, 63, 8'hFF, 0, 0, 1, 1), 0, none);
    add_row(mk_cmd(KIND_CHECK, u_mix, g_mix, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(0, 1, 0, 0, 0));
    add_row(mk_cmd(KIND_READ, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0), 0, none);

    do @(posedge clk_i); while (rst_ni !== 1'b1);

    total = rows.size() + NUM_RANDOM;
    idx   = 0;
    foreach (rows[r]) begin
      set_pacing(idx, total);
      send_cmd(rows[r].cmd, rows[r].fixed, rows[r].want);
      idx++;
    end
    repeat (NUM_RANDOM) begin
      set_pacing(idx, total);
      c = random_cmd();
      send_cmd(c, 1'b0, none);
      idx++;
    end
    req_if.valid <= 1'b0;

    // the watchdog ends the run if results stop coming
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("traffic_quota_table_top regression: pass");
    end else begin
      $display("traffic_quota_table_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/tqt_pkg.sv
design/tqt_chan_if.sv
design/tqt_mem.sv
design/tqt_satadd.sv
design/traffic_quota_table_top.sv
verif/tb.sv
